### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// wraps concurrent assertions so they drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked on every edge outside reset
`define RFE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on edges while reset is held
`define RFE_ASSERT_IN_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);

`else

`define RFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFE_ASSERT_IN_RST(lbl, clk, rst_n, prop, msg)

`endif

`endif

### design/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg
// shared constants and types of the rail fence encryptor
// ----------------------------------------------------------------------------
`default_nettype none

package rfe_pkg;

	localparam int LEN_DEF   = 64;
	localparam int RAILS_DEF = 16;
	localparam int LEN_HI    = 64;
	localparam int RAILS_HI  = 64;

	localparam int DATA_W = 8;
	localparam int CFG_W  = 5;
	localparam logic [CFG_W-1:0] RAIL_CNT_RST = 5'd2;
	localparam logic [CFG_W-1:0] RAIL_CNT_MIN = 5'd2;

	// two message buffers, one per queue slot
	localparam int JOB_DEPTH = 2;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_FILL_W = $clog2(JOB_DEPTH + 1);
	localparam int JOB_CNT_W = $clog2(LEN_HI + 1);
	localparam int JOB_TAG_W = $clog2(RAILS_HI);

	typedef struct packed {
		logic [JOB_CNT_W-1:0] cnt;
		logic [JOB_TAG_W-1:0] top;
		logic                 dropped;
	} job_t;

endpackage

`default_nettype wire

### design/rfe_ram.sv
// ----------------------------------------------------------------------------
// rfe_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/rfe_front.sv
// ----------------------------------------------------------------------------
// rfe_front
// accepts message bytes, walks the zigzag and stores byte and rail tag
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_front #(
	parameter int MAX_LEN   = rfe_pkg::LEN_DEF,
	parameter int MAX_RAILS = rfe_pkg::RAILS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output      logic                                   busy,
	input  wire logic [rfe_pkg::DATA_W-1:0]             plain_byte,
	input  wire logic                                   is_final,
	input  wire logic                                   cfg_valid,
	input  wire logic [rfe_pkg::CFG_W-1:0]              cfg_data,
	input  wire logic                                   q_full,
	input  wire logic [rfe_pkg::JOB_PTR_W-1:0]          wr_bank,
	output      logic                                   push,
	output      rfe_pkg::job_t                          push_job,
	output      logic                                   mem_we,
	output      logic [rfe_pkg::JOB_PTR_W+$clog2(MAX_LEN)-1:0] mem_waddr,
	output      logic [rfe_pkg::DATA_W+$clog2(MAX_RAILS)-1:0] mem_wdata
);

	import rfe_pkg::*;

	localparam int TW = $clog2(MAX_RAILS);
	localparam int IW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [CFG_W-1:0] cfg_q;
	logic [CW-1:0]    cnt_q;
	logic [TW-1:0]    rail_q;
	logic [TW-1:0]    top_q;
	logic             down_q;
	logic             drop_q;

	logic             accept;
	logic             room;
	logic [TW-1:0]    eff_last;
	logic [TW-1:0]    row;
	logic             down_nx;
	logic [TW-1:0]    rail_nx;
	logic [CW-1:0]    cnt_nx;
	logic [TW-1:0]    top_nx;
	logic             drop_nx;

	assign busy   = q_full;
	assign accept = start && !q_full;
	assign room   = cnt_q < CW'(MAX_LEN);

	// rail count clamped to the supported range
	always_comb begin
		if (cfg_q < RAIL_CNT_MIN) begin
			eff_last = TW'(1);
		end else if (int'(cfg_q) > MAX_RAILS) begin
			eff_last = TW'(MAX_RAILS - 1);
		end else begin
			eff_last = TW'(cfg_q - 5'd1);
		end
	end

	always_comb begin
		row = (rail_q > eff_last) ? eff_last : rail_q;
		if (row == '0) begin
			down_nx = 1'b1;
		end else if (row == eff_last) begin
			down_nx = 1'b0;
		end else begin
			down_nx = down_q;
		end
		rail_nx = down_nx ? TW'(row + 1'b1) : TW'(row - 1'b1);
		cnt_nx  = room ? CW'(cnt_q + 1'b1) : cnt_q;
		top_nx  = (room && (row > top_q)) ? row : top_q;
		drop_nx = drop_q | !room;
	end

	assign mem_we    = accept && room;
	assign mem_waddr = {wr_bank, cnt_q[IW-1:0]};
	assign mem_wdata = {row, plain_byte};

	assign push             = accept && is_final;
	assign push_job.cnt     = JOB_CNT_W'(cnt_nx);
	assign push_job.top     = JOB_TAG_W'(top_nx);
	assign push_job.dropped = drop_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= RAIL_CNT_RST;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rail_q <= '0;
			top_q  <= '0;
			down_q <= 1'b0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (is_final) begin
				cnt_q  <= '0;
				rail_q <= '0;
				top_q  <= '0;
				down_q <= 1'b0;
				drop_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_nx;
				rail_q <= rail_nx;
				top_q  <= top_nx;
				down_q <= down_nx;
				drop_q <= drop_nx;
			end
		end
	end

endmodule

`default_nettype wire

### design/rfe_job_queue.sv
// ----------------------------------------------------------------------------
// rfe_job_queue
// queue of finished messages awaiting emission, slot number selects buffer
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rfe_job_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire rfe_pkg::job_t                 push_job,
	input  wire logic                          pop,
	output      rfe_pkg::job_t                 head_job,
	output      logic [rfe_pkg::JOB_PTR_W-1:0] wr_bank,
	output      logic [rfe_pkg::JOB_PTR_W-1:0] rd_bank,
	output      logic                          full,
	output      logic                          empty
);

	import rfe_pkg::*;

	job_t                  slot_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0]  wr_ptr_q;
	logic [JOB_PTR_W-1:0]  rd_ptr_q;
	logic [JOB_FILL_W-1:0] count_q;

	assign wr_bank  = wr_ptr_q;
	assign rd_bank  = rd_ptr_q;
	assign head_job = slot_q[rd_ptr_q];
	assign full     = count_q == JOB_FILL_W'(JOB_DEPTH);
	assign empty    = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= JOB_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= JOB_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= JOB_FILL_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= JOB_FILL_W'(count_q - 1'b1);
			end
		end
	end

	`RFE_ASSERT(a_no_overrun, clk, arst_n, push |-> !full, "push into full job queue")
	`RFE_ASSERT(a_no_underrun, clk, arst_n, pop |-> !empty, "pop from empty job queue")
	`RFE_ASSERT(a_empty_ptrs, clk, arst_n, empty |-> (wr_ptr_q == rd_ptr_q), "pointers split while empty")

endmodule

`default_nettype wire

### design/rfe_back.sv
// ----------------------------------------------------------------------------
// rfe_back
// scans a stored message rail by rail and emits the ciphertext bytes
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rfe_back #(
	parameter int MAX_LEN   = rfe_pkg::LEN_DEF,
	parameter int MAX_RAILS = rfe_pkg::RAILS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   q_empty,
	input  wire rfe_pkg::job_t                          head_job,
	input  wire logic [rfe_pkg::JOB_PTR_W-1:0]          rd_bank,
	output      logic                                   pop,
	output      logic [rfe_pkg::JOB_PTR_W+$clog2(MAX_LEN)-1:0] mem_raddr,
	input  wire logic [rfe_pkg::DATA_W+$clog2(MAX_RAILS)-1:0] mem_rdata,
	output      logic                                   result_strobe,
	output      logic [rfe_pkg::DATA_W-1:0]             cipher_byte,
	output      logic                                   run_last,
	output      logic                                   overflowed
);

	import rfe_pkg::*;

	localparam int TW = $clog2(MAX_RAILS);
	localparam int IW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]        state_q;
	logic [IW-1:0]     idx_q;
	logic [TW-1:0]     rail_q;
	logic              valid_s1;
	logic [TW-1:0]     rail_s1;
	logic              held_v_q;
	logic [DATA_W-1:0] held_byte_q;
	logic              res_strobe_q;
	logic              res_last_q;
	logic [DATA_W-1:0] res_byte_q;
	logic              res_ovf_q;

	logic [CW-1:0]     cnt_last;
	logic [TW-1:0]     top_rail;
	logic              idx_end;
	logic              match;

	assign cnt_last = CW'(CW'(head_job.cnt) - 1'b1);
	assign top_rail = TW'(head_job.top);
	assign idx_end  = CW'(idx_q) == cnt_last;
	assign match    = valid_s1 && (mem_rdata[DATA_W +: TW] == rail_s1);

	assign mem_raddr = {rd_bank, idx_q};
	assign pop       = state_q == ST_FLUSH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			rail_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						rail_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (idx_end) begin
						idx_q  <= '0;
						rail_q <= TW'(rail_q + 1'b1);
						if (rail_q == top_rail) begin
							state_q <= ST_WAIT;
						end
					end else begin
						idx_q <= IW'(idx_q + 1'b1);
					end
				end
				ST_WAIT: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			valid_s1 <= state_q == ST_SCAN;
			if (match) begin
				held_v_q <= 1'b1;
			end else if (state_q == ST_FLUSH) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rail_s1 <= rail_q;
		if (match) begin
			held_byte_q <= mem_rdata[DATA_W-1:0];
		end
	end

	// held byte goes out once the next match proves it is not the last one, or at flush as the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_strobe_q <= 1'b0;
			res_last_q   <= 1'b0;
		end else begin
			res_strobe_q <= (match && held_v_q) || (state_q == ST_FLUSH);
			res_last_q   <= state_q == ST_FLUSH;
		end
	end

	always_ff @(posedge clk) begin
		res_byte_q <= held_byte_q;
		res_ovf_q  <= head_job.dropped;
	end

	assign result_strobe = res_strobe_q;
	assign cipher_byte   = res_byte_q;
	assign run_last      = res_last_q;
	assign overflowed    = res_ovf_q;

	`RFE_ASSERT(a_flush_held, clk, arst_n, (state_q == ST_FLUSH) |-> held_v_q, "flush with no byte held")
	`RFE_ASSERT(a_flush_last, clk, arst_n, (state_q == ST_FLUSH) |=> (result_strobe && run_last), "final byte not emitted after flush")
	`RFE_ASSERT(a_last_strobe, clk, arst_n, run_last |-> result_strobe, "last flag without strobe")
	`RFE_ASSERT(a_job_present, clk, arst_n, (state_q != ST_IDLE) |-> !q_empty, "scan without a queued message")
	`RFE_ASSERT_IN_RST(a_rst_quiet, clk, arst_n, !result_strobe, "result strobe during reset")

endmodule

`default_nettype wire

### design/rail_fence_encrypt_unit.sv
// ----------------------------------------------------------------------------
// rail_fence_encrypt_unit
// rail fence (zigzag) encryptor, one plaintext byte per request
// ----------------------------------------------------------------------------
// A byte is taken on every cycle with start high and busy low. The request
// flagged is_final starts emission: the message is scanned from RAM one
// entry per cycle for each rail up to the highest rail used. Two message
// buffers let the next message load while one is emitted; busy is high
// only while both hold messages not yet fully emitted. Each result is on
// the outputs for one cycle with result_strobe high and cannot be held off;
// run_last marks the last byte. Bytes past MAX_LEN are dropped and
// overflowed is set on every result of that message. A rail_count below 2
// acts as 2 and above MAX_RAILS as MAX_RAILS; write it only while no
// message is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rail_fence_encrypt_unit #(
	parameter int MAX_LEN   = rfe_pkg::LEN_DEF,
	parameter int MAX_RAILS = rfe_pkg::RAILS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output      logic                       busy,
	input  wire logic [rfe_pkg::DATA_W-1:0] plain_byte,
	input  wire logic                       is_final,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [rfe_pkg::CFG_W-1:0]  cfg_data,
	output      logic                       result_strobe,
	output      logic [rfe_pkg::DATA_W-1:0] cipher_byte,
	output      logic                       run_last,
	output      logic                       overflowed
);

	import rfe_pkg::*;

	localparam int TW    = $clog2(MAX_RAILS);
	localparam int IW    = $clog2(MAX_LEN);
	localparam int AW    = JOB_PTR_W + IW;
	localparam int MW    = DATA_W + TW;
	localparam int DEPTH = JOB_DEPTH << IW;

	logic                 q_full;
	logic                 q_empty;
	logic                 push;
	logic                 pop;
	job_t                 push_job;
	job_t                 head_job;
	logic [JOB_PTR_W-1:0] wr_bank;
	logic [JOB_PTR_W-1:0] rd_bank;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [MW-1:0]        mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [MW-1:0]        mem_rdata;

	assign cfg_ready = 1'b1;

	rfe_front #(
		.MAX_LEN   (MAX_LEN),
		.MAX_RAILS (MAX_RAILS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.plain_byte (plain_byte),
		.is_final   (is_final),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.wr_bank    (wr_bank),
		.push       (push),
		.push_job   (push_job),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata)
	);

	rfe_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.wr_bank  (wr_bank),
		.rd_bank  (rd_bank),
		.full     (q_full),
		.empty    (q_empty)
	);

	rfe_ram #(
		.WIDTH (MW),
		.DEPTH (DEPTH)
	) u_msg_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	rfe_back #(
		.MAX_LEN   (MAX_LEN),
		.MAX_RAILS (MAX_RAILS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head_job      (head_job),
		.rd_bank       (rd_bank),
		.pop           (pop),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.result_strobe (result_strobe),
		.cipher_byte   (cipher_byte),
		.run_last      (run_last),
		.overflowed    (overflowed)
	);

endmodule

`default_nettype wire

### sim/tb_rail_fence_encrypt_unit.sv
// ----------------------------------------------------------------------------
// tb_rail_fence_encrypt_unit
// self-checking bench for the rail fence encryptor
// ----------------------------------------------------------------------------
// Plaintext messages are fed one byte per request, some with random gaps. A
// scoreboard places each accepted byte on its zigzag rail, builds the
// rail-by-rail ciphertext when the final byte is taken, and compares every
// strobed output byte with it. rail_count is swept over in-range and
// out-of-range values between messages. Long messages fill the store exactly
// or overflow it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rail_fence_encrypt_unit;

	import rfe_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_TARGET = 237;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
		logic              ovf;
	} cipher_t;

	class cipher_tracker;
		logic [DATA_W-1:0] held_byte [LEN_DEF];
		int unsigned       held_rail [LEN_DEF];
		int unsigned       held_cnt;
		int unsigned       next_rail;
		int unsigned       rail_cfg;
		bit                going_down;
		bit                lost_bytes;
		cipher_t           cipher_due [$];
		int unsigned       mismatches;
		int unsigned       seen;

		function new();
			rail_cfg = RAIL_CNT_RST;
			mismatches = 0;
			seen = 0;
			clear_message();
		endfunction

		function void clear_message();
			held_cnt = 0;
			next_rail = 0;
			going_down = 1'b0;
			lost_bytes = 1'b0;
		endfunction

		function void set_rails(input logic [CFG_W-1:0] v);
			rail_cfg = v;
		endfunction

		function void note_plain(input logic [DATA_W-1:0] b, input bit fin);
			int unsigned top;
			int unsigned row;
			int unsigned r;
			int unsigned i;
			cipher_t     prev;
			bit          have;
			top = rail_cfg;
			if (top < 2) top = 2;
			if (top > RAILS_DEF) top = RAILS_DEF;
			top = top - 1;
			row = next_rail;
			if (row > top) row = top;
			if (row == 0) going_down = 1'b1;
			else if (row == top) going_down = 1'b0;
			if (held_cnt < LEN_DEF) begin
				held_byte[held_cnt] = b;
				held_rail[held_cnt] = row;
				held_cnt++;
			end else begin
				lost_bytes = 1'b1;
			end
			next_rail = going_down ? row + 1 : row - 1;
			if (!fin) return;
			have = 1'b0;
			prev = '0;
			for (r = 0; r < RAILS_DEF; r++) begin
				for (i = 0; i < held_cnt; i++) begin
					if (held_rail[i] == r) begin
						if (have) cipher_due.push_back(prev);
						prev.data = held_byte[i];
						prev.last = 1'b0;
						prev.ovf = lost_bytes;
						have = 1'b1;
					end
				end
			end
			if (have) begin
				prev.last = 1'b1;
				cipher_due.push_back(prev);
			end
			clear_message();
		endfunction

		task report(input string msg);
			$display("mismatch at result %0d: %s", seen, msg);
			mismatches++;
		endtask

		task check_cipher(input logic [DATA_W-1:0] b, input logic last, input logic ovf);
			cipher_t want;
			seen++;
			if (cipher_due.size() == 0) begin
				report($sformatf("unexpected byte %02h", b));
			end else begin
				want = cipher_due.pop_front();
				if (b !== want.data)
					report($sformatf("cipher_byte %02h, want %02h", b, want.data));
				if (last !== want.last)
					report($sformatf("run_last %b, want %b", last, want.last));
				if (ovf !== want.ovf)
					report($sformatf("overflowed %b, want %b", ovf, want.ovf));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [DATA_W-1:0] plain_byte;
	logic              is_final;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data;
	logic              result_strobe;
	logic [DATA_W-1:0] cipher_byte;
	logic              run_last;
	logic              overflowed;

	cipher_tracker tracker;
	int unsigned   plain_sent;
	int unsigned   msgs_sent;
	int unsigned   cfg_writes;
	int unsigned   stall_cycles;

	rail_fence_encrypt_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.plain_byte(plain_byte),
		.is_final(is_final),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.cipher_byte(cipher_byte),
		.run_last(run_last),
		.overflowed(overflowed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe) tracker.check_cipher(cipher_byte, run_last, overflowed);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no request or result for %0d cycles", STALL_LIMIT);
			$display("tb_rail_fence_encrypt_unit NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_plain(input logic [DATA_W-1:0] b, input bit fin, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		plain_byte <= b;
		is_final <= fin;
		do @(posedge clk); while (busy);
		tracker.note_plain(b, fin);
		plain_sent++;
		if (fin) msgs_sent++;
	endtask

	task automatic send_message(input int len, input bit gappy);
		int i;
		for (i = 0; i < len; i++)
			send_plain(8'($urandom_range(0, 255)), i == len - 1,
				gappy ? int'($urandom_range(0, 19)) : 0);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.cipher_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_rails(input logic [CFG_W-1:0] v);
		drain();
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_rails(v);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] rails_plan [7];
		logic [CFG_W-1:0] rails;
		int               phase;
		int               i;
		int unsigned      directed_sent;
		bit               gappy;

		tracker = new();
		plain_sent = 0;
		msgs_sent = 0;
		cfg_writes = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		plain_byte = '0;
		is_final = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rails_plan = '{5'd0, 5'd1, 5'd3, 5'd16, 5'd17, 5'd31, 5'd2};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-byte message, then edge values and a '.' on two rails
		send_plain(8'h00, 1'b1, 0);
		send_plain(8'hFF, 1'b0, 0);
		send_plain(8'h2E, 1'b0, 0);
		send_plain(8'h80, 1'b0, 0);
		send_plain(8'h01, 1'b0, 0);
		send_plain(8'h7F, 1'b1, 0);

		// above max rails, full zigzag down to the last rail and back up
		write_rails(5'd31);
		for (i = 0; i < 17; i++) send_plain(8'(i * 15), i == 16, 0);
		directed_sent = plain_sent;

		phase = 0;
		while (phase < 7 || plain_sent - directed_sent < RANDOM_TARGET) begin
			rails = (phase < 7) ? rails_plan[phase] : 5'($urandom_range(0, 31));
			write_rails(rails);
			gappy = $urandom_range(0, 2) != 0;
			// exactly full store, then one that overflows
			if (phase == 1) send_message(LEN_DEF, gappy);
			if (phase == 3) send_message($urandom_range(LEN_DEF + 1, LEN_DEF + 6), gappy);
			repeat ($urandom_range(2, 3)) send_message($urandom_range(1, 12), gappy);
			phase++;
		end

		drain();
		repeat (50) @(posedge clk);

		$display("%0d messages, %0d plaintext bytes, %0d cipher bytes checked",
			msgs_sent, plain_sent, tracker.seen);
		$display("%0d rail_count writes incl. clamped values, full and overflowing store",
			cfg_writes);
		if (tracker.mismatches == 0 && tracker.cipher_due.size() == 0) begin
			$display("tb_rail_fence_encrypt_unit OK");
		end else begin
			$display("tb_rail_fence_encrypt_unit NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/rfe_pkg.sv
design/rfe_ram.sv
design/rfe_front.sv
design/rfe_job_queue.sv
design/rfe_back.sv
design/rail_fence_encrypt_unit.sv
sim/tb_rail_fence_encrypt_unit.sv
